// ===== hw/rtl/wfsb_pkg.sv =====
// shared types, constants and twiddle table builder for the spectrum bar core
package wfsb_pkg;

    // default configuration
    localparam int RING_SIZE_DEF   = 1024;
    localparam int NUM_BARS_DEF    = 40;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int RAW_W     = 24;
    localparam int INDEX_W   = 6;
    localparam int LEVEL_W   = 16;
    localparam int MAG_W     = 26;
    localparam int TW_W      = 26;
    localparam int TW_FRAC   = 24;
    localparam int ROOT_ITER = 27;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    // input request payload
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } wfsb_in_t;

    // result request payload
    typedef struct packed {
        logic [INDEX_W-1:0] bar_index;
        logic [LEVEL_W-1:0] bar_level;
        logic [MAG_W-1:0]   peak_magnitude;
        logic               last;
    } wfsb_out_t;

    // unsigned quotient by shift and subtract, small divisors only
    function automatic longint unsigned div_small(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // taylor series in q30 on [0, pi/2], odd selects sine
    function automatic longint taylor_q30(longint unsigned x, bit odd);
        longint unsigned x2;
        longint unsigned t;
        longint unsigned d;
        longint          sum;
        x2  = (x * x) >> 30;
        t   = odd ? x : ONE_Q30;
        sum = longint'(t);
        for (int i = 1; i <= 9; i++) begin
            d = odd ? longint'(2 * i) * longint'(2 * i + 1)
                    : longint'(2 * i - 1) * longint'(2 * i);
            t = div_small((t * x2) >> 30, d);
            if ((i & 1) == 1) sum = sum - longint'(t);
            else              sum = sum + longint'(t);
        end
        return sum;
    endfunction

    // q30 to q24, half away from zero
    function automatic longint round_q24(longint v);
        longint m;
        if (v < 0) begin
            m = -v;
            return -((m + 32) >>> 6);
        end
        return (v + 32) >>> 6;
    endfunction

    // quarter wave entry j of a table of 2^lg points: {cos, sin} in q1.24
    function automatic logic [2*TW_W-1:0] tw_entry(int j, int lg);
        longint unsigned x;
        longint          c;
        longint          s;
        x = (HALF_PI_Q30 * longint'(4 * j) + (64'd1 << (lg - 1))) >> lg;
        c = taylor_q30(x, 1'b0);
        s = taylor_q30(x, 1'b1);
        return {TW_W'(round_q24(c)), TW_W'(round_q24(s))};
    endfunction

endpackage

// ===== hw/rtl/windowed_fft_spectrum_bars_core.sv =====
// top level: spectrum bar core with sample ring, run queue and bin engine
// a block end request gives its first bar only after all bins are done,
//   as every bin is computed in turn by the single shared mac unit
// bars then leave one at a time through the serial divider, held while the output is not taken
// samples are taken one per cycle while no run is pending or active
// reset: synchronous active low; the ring is zeroed by a clearing pass
//   after reset, during which no request is accepted
module windowed_fft_spectrum_bars_core #(
    parameter int RING_SIZE   = wfsb_pkg::RING_SIZE_DEF,
    parameter int NUM_BARS    = wfsb_pkg::NUM_BARS_DEF,
    parameter int SAMPLE_BITS = wfsb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wfsb_pkg::wfsb_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wfsb_pkg::wfsb_out_t m_data
);
    import wfsb_pkg::*;

    localparam int AW = $clog2(RING_SIZE);

    logic                   push_valid;
    logic [AW-1:0]          push_ptr;
    logic                   q_valid;
    logic [AW-1:0]          q_ptr;
    logic                   q_full;
    logic                   q_pop;
    logic [AW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   back_busy;
    logic                   run_busy;

    assign run_busy = q_valid || q_full || back_busy;

    // front: ring writes and run requests
    wfsb_front #(
        .RING_SIZE   (RING_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .run_busy   (run_busy),
        .push_valid (push_valid),
        .push_ptr   (push_ptr),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // run request queue
    wfsb_queue #(
        .PTR_W (AW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_ptr),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_ptr),
        .full      (q_full)
    );

    // back: bins, peak and bar levels
    wfsb_back #(
        .RING_SIZE   (RING_SIZE),
        .NUM_BARS    (NUM_BARS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ptr   (q_ptr),
        .cmd_pop   (q_pop),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .busy      (back_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // level never exceeds one
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.bar_level <= 16'd32768)
        else $error("bar level above one");

    // zero peak gives zero levels
    a_zero_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.peak_magnitude == '0) |-> m_data.bar_level == '0)
        else $error("nonzero level with zero peak");

    // no sample taken while a run waits in the queue
    a_ring_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !q_valid)
        else $error("sample accepted while run pending");

    // last marks the final bar only
    a_last_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last) |-> m_data.bar_index == INDEX_W'(NUM_BARS - 1))
        else $error("last on wrong bar");

endmodule

// ===== hw/rtl/wfsb_front.sv =====
// sample ring with write side, clearing pass and run request issue
module wfsb_front #(
    parameter int RING_SIZE   = wfsb_pkg::RING_SIZE_DEF,
    parameter int SAMPLE_BITS = wfsb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wfsb_pkg::wfsb_in_t             s_data,
    input  logic                           run_busy,
    output logic                           push_valid,
    output logic [$clog2(RING_SIZE)-1:0]   push_ptr,
    input  logic [$clog2(RING_SIZE)-1:0]   rd_addr,
    output logic [SAMPLE_BITS-1:0]         rd_data
);
    import wfsb_pkg::*;

    localparam int AW = $clog2(RING_SIZE);

    logic [SAMPLE_BITS-1:0] ring [RING_SIZE];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [AW-1:0]          clr_cnt_reg;
    logic                   clr_done_reg;
    logic [AW-1:0]          wp_reg;
    logic                   accept;
    logic [RAW_W-1:0]       raw;

    assign s_ready    = clr_done_reg && !run_busy;
    assign accept     = s_valid && s_ready;
    assign raw        = {{(RAW_W-SAMPLE_W){1'b0}}, s_data.sample};
    assign push_valid = accept && s_data.block_end;
    assign push_ptr   = wp_reg + AW'(1);
    assign rd_data    = rd_data_reg;

    // clearing pass and write pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
            wp_reg       <= '0;
        end else if (!clr_done_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(RING_SIZE - 1)) clr_done_reg <= 1'b1;
        end else if (accept) begin
            wp_reg <= wp_reg + AW'(1);
        end
    end

    // ring memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (!clr_done_reg) begin
            ring[clr_cnt_reg] <= '0;
        end else if (accept) begin
            ring[wp_reg] <= raw[SAMPLE_BITS-1:0];
        end
        rd_data_reg <= ring[rd_addr];
    end

endmodule

// ===== hw/rtl/wfsb_queue.sv =====
// two entry queue of run requests carrying the oldest sample pointer
module wfsb_queue #(
    parameter int PTR_W = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [PTR_W-1:0] push_data,
    input  logic             pop,
    output logic             pop_valid,
    output logic [PTR_W-1:0] pop_data,
    output logic             full
);
    import wfsb_pkg::*;

    logic [PTR_W-1:0] entry_reg [2];
    logic             wr_reg;
    logic             rd_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign pop_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop_data  = entry_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (do_push) wr_reg <= ~wr_reg;
            if (do_pop)  rd_reg <= ~rd_reg;
            if (do_push && !do_pop)      count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push) count_reg <= count_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/wfsb_back.sv =====
// dft bins by shared mac, magnitude root, peak search and bar level division
module wfsb_back #(
    parameter int RING_SIZE   = wfsb_pkg::RING_SIZE_DEF,
    parameter int NUM_BARS    = wfsb_pkg::NUM_BARS_DEF,
    parameter int SAMPLE_BITS = wfsb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    input  logic [$clog2(RING_SIZE)-1:0]   cmd_ptr,
    output logic                           cmd_pop,
    output logic [$clog2(RING_SIZE)-1:0]   rd_addr,
    input  logic [SAMPLE_BITS-1:0]         rd_data,
    output logic                           busy,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wfsb_pkg::wfsb_out_t            m_data
);
    import wfsb_pkg::*;

    localparam int AW     = $clog2(RING_SIZE);
    localparam int QW     = AW - 2;
    localparam int QN     = RING_SIZE / 4;
    localparam int HALF_N = RING_SIZE / 2;
    localparam int BW     = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
    localparam int PW     = SAMPLE_BITS + TW_W;
    localparam int ACC_W  = PW + AW;
    localparam int RW     = (ACC_W > MAG_W + 1) ? ACC_W : MAG_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int RAD_W  = 2 * ROOT_ITER;
    localparam int RT_W   = MAG_W + 1;
    localparam int RM_W   = MAG_W + 3;

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BIN   = 4'd1;
    localparam logic [3:0] ST_MAC   = 4'd2;
    localparam logic [3:0] ST_RND   = 4'd3;
    localparam logic [3:0] ST_SQ    = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_ROOT  = 4'd6;
    localparam logic [3:0] ST_STORE = 4'd7;
    localparam logic [3:0] ST_DRD   = 4'd8;
    localparam logic [3:0] ST_DLD   = 4'd9;
    localparam logic [3:0] ST_DIV   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    // twiddle quarter table
    logic [2*TW_W-1:0] tw_tab [QN];
    for (genvar g = 0; g < QN; g++) begin : g_tw
        localparam logic [2*TW_W-1:0] ENTRY = tw_entry(g, AW);
        assign tw_tab[g] = ENTRY;
    end

    logic [AW-1:0]             start_reg;
    logic [BW-1:0]             k_reg;
    logic [AW-1:0]             pos_reg;
    logic [AW-1:0]             idx_reg;
    logic [AW-1:0]             n_reg;
    logic                      issuing_reg;
    logic [AW-1:0]             step;
    logic                      above_nyq;
    logic                      last_bar;

    // mac pipeline
    logic                      v1_reg, v2_reg, v3_reg;
    logic [1:0]                q1_reg;
    logic [2*TW_W-1:0]         tw_rd_reg;
    logic signed [TW_W-1:0]    c1, s1, cos1, sin1;
    logic signed [SAMPLE_BITS-1:0] x2_reg;
    logic signed [TW_W-1:0]    cos2_reg, sin2_reg;
    logic signed [PW-1:0]      pr_reg, pi_reg;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_im_reg;

    // magnitude
    logic [ACC_W-1:0]          abs_re, abs_im;
    logic [RW-1:0]             ar_full, ai_full;
    logic [MAG_W-1:0]          ar_reg, ai_reg;
    logic                      sat_reg;
    logic [SQ_W-1:0]           sq_re_reg, sq_im_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [RT_W-1:0]           root_reg;
    logic [RM_W-1:0]           rem_reg;
    logic [RM_W+1:0]           rem_t, trial;
    logic [4:0]                it_reg;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          peak_reg;

    // bar magnitude store
    logic [MAG_W-1:0]          bar_mem [NUM_BARS];
    logic [MAG_W-1:0]          bar_rd_reg;
    logic                      bar_we;

    // divider
    logic [MAG_W-1:0]          drem_reg;
    logic [LEVEL_W-1:0]        dlo_reg;
    logic [LEVEL_W-1:0]        quo_reg;
    logic [MAG_W:0]            dt;
    logic                      dge;

    logic                      m_valid_reg;
    wfsb_out_t                 m_data_reg;
    logic                      out_free;

    assign step      = AW'(32'(k_reg) + 32'd1);
    assign above_nyq = (32'(k_reg) + 32'd1) > 32'(HALF_N);
    assign last_bar  = (k_reg == BW'(NUM_BARS - 1));
    assign rd_addr   = pos_reg;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign busy      = (state_reg != ST_IDLE) || m_valid_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // twiddle sign by quadrant
    assign c1 = signed'(tw_rd_reg[2*TW_W-1:TW_W]);
    assign s1 = signed'(tw_rd_reg[TW_W-1:0]);
    always_comb begin
        unique case (q1_reg)
            2'd0: begin cos1 = c1;  sin1 = s1;  end
            2'd1: begin cos1 = -s1; sin1 = c1;  end
            2'd2: begin cos1 = -c1; sin1 = -s1; end
            default: begin cos1 = s1; sin1 = -c1; end
        endcase
    end

    // absolute value and rounding to sample lsbs, kept full width for the saturation check
    assign abs_re  = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
    assign abs_im  = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
    assign ar_full = (RW'(abs_re) + RW'(1 << (TW_FRAC - 1))) >> TW_FRAC;
    assign ai_full = (RW'(abs_im) + RW'(1 << (TW_FRAC - 1))) >> TW_FRAC;

    // root digit step
    assign rem_t = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign mag   = (sat_reg || root_reg > RT_W'(MAG_MAX)) ? MAG_MAX
                                                          : root_reg[MAG_W-1:0];
    assign bar_we = (state_reg == ST_STORE);

    // divider step
    assign dt  = {drem_reg, dlo_reg[LEVEL_W-1]};
    assign dge = dt >= {1'b0, peak_reg};

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (cmd_valid) state_next = ST_BIN;
            ST_BIN:   state_next = above_nyq ? ST_STORE : ST_MAC;
            ST_MAC:   if (!issuing_reg && !v1_reg && !v2_reg && !v3_reg)
                          state_next = ST_RND;
            ST_RND:   state_next = ST_SQ;
            ST_SQ:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_ROOT;
            ST_ROOT:  if (it_reg == 5'(ROOT_ITER - 1)) state_next = ST_STORE;
            ST_STORE: state_next = last_bar ? ST_DRD : ST_BIN;
            ST_DRD:   state_next = ST_DLD;
            ST_DLD:   state_next = ST_DIV;
            ST_DIV:   if (it_reg == 5'(LEVEL_W - 1)) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = last_bar ? ST_IDLE : ST_DRD;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issuing_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            peak_reg    <= '0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_MAC) && issuing_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (state_reg == ST_BIN) issuing_reg <= !above_nyq;
            else if (state_reg == ST_MAC && issuing_reg && n_reg == AW'(RING_SIZE - 1))
                issuing_reg <= 1'b0;
            if (cmd_pop) peak_reg <= '0;
            else if (bar_we && (above_nyq ? 1'b0 : mag > peak_reg)) peak_reg <= mag;
            if (state_reg == ST_OUT && out_free) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)     m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        // run and bin bookkeeping
        if (cmd_pop) begin
            start_reg <= cmd_ptr;
            k_reg     <= '0;
        end
        if (state_reg == ST_STORE && !last_bar) k_reg <= k_reg + BW'(1);
        if (state_reg == ST_STORE && last_bar)  k_reg <= '0;
        if (state_reg == ST_OUT && out_free)    k_reg <= k_reg + BW'(1);
        if (state_reg == ST_BIN) begin
            pos_reg    <= start_reg;
            idx_reg    <= '0;
            n_reg      <= '0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        // issue stage
        if (state_reg == ST_MAC && issuing_reg) begin
            pos_reg <= pos_reg + AW'(1);
            idx_reg <= idx_reg + step;
            n_reg   <= n_reg + AW'(1);
        end
        tw_rd_reg <= tw_tab[idx_reg[QW-1:0]];
        q1_reg    <= idx_reg[AW-1:QW];
        // operand stage
        x2_reg   <= signed'(rd_data);
        cos2_reg <= cos1;
        sin2_reg <= sin1;
        // product stage
        pr_reg <= PW'(x2_reg) * PW'(cos2_reg);
        pi_reg <= PW'(x2_reg) * PW'(sin2_reg);
        // accumulate stage
        if (v3_reg) begin
            acc_re_reg <= acc_re_reg + ACC_W'(pr_reg);
            acc_im_reg <= acc_im_reg - ACC_W'(pi_reg);
        end
        // rounding
        if (state_reg == ST_RND) begin
            ar_reg  <= ar_full[MAG_W-1:0];
            ai_reg  <= ai_full[MAG_W-1:0];
            sat_reg <= (ar_full > RW'(MAG_MAX)) || (ai_full > RW'(MAG_MAX));
        end
        // squares
        if (state_reg == ST_SQ) begin
            sq_re_reg <= SQ_W'(ar_reg) * SQ_W'(ar_reg);
            sq_im_reg <= SQ_W'(ai_reg) * SQ_W'(ai_reg);
        end
        // root setup and digit steps
        if (state_reg == ST_SUM) begin
            rad_reg  <= RAD_W'(sq_re_reg) + RAD_W'(sq_im_reg);
            root_reg <= '0;
            rem_reg  <= '0;
            it_reg   <= '0;
        end
        if (state_reg == ST_ROOT) begin
            rad_reg <= rad_reg << 2;
            it_reg  <= it_reg + 5'd1;
            if (rem_t >= trial) begin
                rem_reg  <= RM_W'(rem_t - trial);
                root_reg <= {root_reg[RT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= RM_W'(rem_t);
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
        end
        // divider setup and steps
        if (state_reg == ST_DLD) begin
            drem_reg <= bar_rd_reg >> 1;
            dlo_reg  <= {bar_rd_reg[0], {(LEVEL_W-1){1'b0}}};
            quo_reg  <= '0;
            it_reg   <= '0;
        end
        if (state_reg == ST_DIV) begin
            it_reg  <= it_reg + 5'd1;
            dlo_reg <= dlo_reg << 1;
            quo_reg <= {quo_reg[LEVEL_W-2:0], dge};
            drem_reg <= dge ? MAG_W'(dt - {1'b0, peak_reg}) : MAG_W'(dt);
        end
        // result register
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg.bar_index      <= INDEX_W'(k_reg);
            m_data_reg.bar_level      <= (peak_reg == '0) ? '0 : quo_reg;
            m_data_reg.peak_magnitude <= peak_reg;
            m_data_reg.last           <= last_bar;
        end
    end

    // bar magnitude memory
    always_ff @(posedge aclk) begin
        if (bar_we) bar_mem[k_reg] <= above_nyq ? '0 : mag;
        bar_rd_reg <= bar_mem[k_reg];
    end

endmodule
